/* design/imdd_pkg.sv */
package imdd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int FRAC_W   = 16;
  localparam int AVG_W    = DIFF_W + FRAC_W;
  localparam int WEIGHT_W = 16;
  localparam int THR_W    = 16;
  localparam int TIME_W   = 32;
  localparam int CODE_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET   = 16'd3277;
  localparam logic [THR_W-1:0]    THRESHOLD_RESET = 16'd11;
  localparam logic [TIME_W-1:0]   INTERVAL_RESET  = 32'd100;

  // per-axis direction codes
  localparam logic [1:0] CODE_RISE = 2'd1;
  localparam logic [1:0] CODE_FALL = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT_13 = 3'd0,
    REG_WEIGHT_24 = 3'd1,
    REG_MOVE_THR  = 3'd2,
    REG_CHECK_INT = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic rise;
    logic fall;
  } imdd_dir_t;

  typedef struct packed {
    logic valid;
    logic read;
    logic check;
  } imdd_stage_t;

endpackage

/* design/imdd_lane.sv */
module imdd_lane import imdd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     upd,
  input  logic signed [DIFF_W-1:0] diff,
  input  logic [WEIGHT_W-1:0]      weight,
  input  logic                     chk,
  input  logic [THR_W-1:0]         thr,
  output imdd_dir_t                dir
);

  localparam int ERR_W  = AVG_W + 1;
  localparam int PROD_W = ERR_W + WEIGHT_W + 1;
  localparam int STEP_W = PROD_W - FRAC_W;

  logic signed [AVG_W-1:0]  avg;
  logic signed [AVG_W-1:0]  mark;
  logic signed [AVG_W-1:0]  avg_next;
  logic signed [AVG_W-1:0]  target;
  logic signed [ERR_W-1:0]  err;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [STEP_W-1:0] step;
  logic signed [STEP_W-1:0] sum;
  logic signed [ERR_W-1:0]  delta;
  logic signed [ERR_W-1:0]  thr_q;

  assign target   = {diff, {FRAC_W{1'b0}}};
  assign err      = {target[AVG_W-1], target} - {avg[AVG_W-1], avg};
  assign prod     = $signed({1'b0, weight}) * err;
  // round half up, then floor by arithmetic shift
  assign prod_rnd = prod + $signed(PROD_W'(1) <<< (FRAC_W - 1));
  assign step     = prod_rnd[PROD_W-1:FRAC_W];
  assign sum      = {{(STEP_W-AVG_W){avg[AVG_W-1]}}, avg} + step;
  assign avg_next = sum[AVG_W-1:0];

  assign delta = {avg[AVG_W-1], avg} - {mark[AVG_W-1], mark};
  assign thr_q = $signed({{(ERR_W-THR_W-FRAC_W){1'b0}}, thr, {FRAC_W{1'b0}}});

  assign dir.rise = delta > thr_q;
  assign dir.fall = delta < -thr_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      avg  <= '0;
      mark <= '0;
    end else begin
      if (upd) avg <= avg_next;
      // avg here already holds the value after the checked sample
      if (chk) mark <= avg;
    end
  end

endmodule

/* design/imdd_merge.sv */
module imdd_merge import imdd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  imdd_stage_t       stage,
  input  imdd_dir_t         dir13,
  input  imdd_dir_t         dir24,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [CODE_W-1:0] out_code,
  output logic              stall
);

  logic [CODE_W-1:0] sticky;
  logic [CODE_W-1:0] sticky_next;
  logic              go;

  assign stall = stage.valid & stage.read & out_valid & ~out_ready;
  assign go    = stage.valid & stage.read & ~stall;

  always_comb begin
    sticky_next = sticky;
    if (stage.valid & stage.check) begin
      if (dir13.rise)      sticky_next[1:0] = CODE_RISE;
      else if (dir13.fall) sticky_next[1:0] = CODE_FALL;
      if (dir24.rise)      sticky_next[3:2] = CODE_RISE;
      else if (dir24.fall) sticky_next[3:2] = CODE_FALL;
    end
    if (go) sticky_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sticky    <= '0;
      out_valid <= 1'b0;
    end else begin
      sticky <= sticky_next;
      if (go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) out_code <= sticky;
  end

endmodule

/* design/ir_motion_direction_detector_top.sv */
// IR motion direction detector.
// Input stream s_*: one beat is either a sample (tuser = 0) carrying four
// signed IR channels and a millisecond timestamp, or a read request
// (tuser = 1). Samples produce no output; each read produces one beat on
// m_* with the sticky movement code, which is cleared by the read.
// cfg_*: register writes (0 weight 1-3, 1 weight 2-4, 2 threshold,
// 3 check interval), always ready; write only while the block is idle.
// Throughput: one input beat per cycle while s_tready is high. Each axis lane
// updates its average in the accept cycle with one 17x34 multiply in its
// feedback loop; the direction check and the read run in the next cycle in
// the merge stage, and a read's result goes through the stage register and
// the output register to m_*. If m_tready is low, the output register holds
// the result and samples keep flowing; s_tready drops only when a second
// read reaches the merge stage while the first result still waits.
// Reset clears averages, marks, last check time, sticky code and loads the
// register defaults; no output is pending after reset.
module ir_motion_direction_detector_top import imdd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // ir_one[15:0], ir_two[31:16], ir_three[47:32], ir_four[63:48], now_ms[95:64]
  input  logic [95:0]           s_tdata,
  // kind[0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // movement_code[3:0], zero pad[7:4]
  output logic [7:0]            m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [WEIGHT_W-1:0] weight_axis13;
  logic [WEIGHT_W-1:0] weight_axis24;
  logic [THR_W-1:0]    move_threshold;
  logic [TIME_W-1:0]   check_interval_ms;
  logic [TIME_W-1:0]   last_check_ms;

  logic signed [SAMPLE_W-1:0] ir_one, ir_two, ir_three, ir_four;
  logic [TIME_W-1:0]          now_ms;
  logic [TIME_W-1:0]          elapsed;
  logic signed [DIFF_W-1:0]   diff13, diff24;
  logic                       accept, sample, check;
  logic                       stall;
  imdd_stage_t                stage;
  imdd_dir_t                  dir13, dir24;
  logic [CODE_W-1:0]          code;

  assign ir_one   = s_tdata[15:0];
  assign ir_two   = s_tdata[31:16];
  assign ir_three = s_tdata[47:32];
  assign ir_four  = s_tdata[63:48];
  assign now_ms   = s_tdata[95:64];

  assign s_tready  = ~stall;
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid & s_tready;
  assign sample    = accept & ~s_tuser;
  assign elapsed   = now_ms - last_check_ms;
  assign check     = sample & (elapsed > check_interval_ms);

  assign diff13 = DIFF_W'(ir_one) - DIFF_W'(ir_three);
  assign diff24 = DIFF_W'(ir_two) - DIFF_W'(ir_four);

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_axis13     <= WEIGHT_RESET;
      weight_axis24     <= WEIGHT_RESET;
      move_threshold    <= THRESHOLD_RESET;
      check_interval_ms <= INTERVAL_RESET;
    end else if (cfg_valid & cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_WEIGHT_13: weight_axis13     <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_24: weight_axis24     <= cfg_data[WEIGHT_W-1:0];
        REG_MOVE_THR:  move_threshold    <= cfg_data[THR_W-1:0];
        REG_CHECK_INT: check_interval_ms <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_check_ms <= '0;
      stage         <= '0;
    end else begin
      if (check) last_check_ms <= now_ms;
      // only a read can stall here, so a check is never repeated
      if (!stall) begin
        stage.valid <= accept;
        stage.read  <= accept & s_tuser;
        stage.check <= check;
      end
    end
  end

  imdd_lane u_lane13 (
    .clk    (clk),
    .rst    (rst),
    .upd    (sample),
    .diff   (diff13),
    .weight (weight_axis13),
    .chk    (stage.valid & stage.check),
    .thr    (move_threshold),
    .dir    (dir13)
  );

  imdd_lane u_lane24 (
    .clk    (clk),
    .rst    (rst),
    .upd    (sample),
    .diff   (diff24),
    .weight (weight_axis24),
    .chk    (stage.valid & stage.check),
    .thr    (move_threshold),
    .dir    (dir24)
  );

  imdd_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .dir13     (dir13),
    .dir24     (dir24),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_code  (code),
    .stall     (stall)
  );

  assign m_tdata = {{(8-CODE_W){1'b0}}, code};

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (stage.valid && stage.read && m_tvalid && !m_tready))
    else $error("input stalled without a blocked read");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (stage.valid && stage.read && !stall) |=> m_tvalid)
    else $error("read left merge stage without a result");

  a_check_sample: assert property (@(posedge clk) disable iff (rst)
    (stage.valid && stage.check) |-> !stage.read)
    else $error("check flagged on a read beat");

  a_check_time: assert property (@(posedge clk) disable iff (rst)
    check |=> (last_check_ms == $past(now_ms)))
    else $error("last check time not updated");
`endif

endmodule
